/* sv/tzvd_pkg.sv */
// ----------------------------------------------------------------------------
// tzvd_pkg
// Types, constants and code tables for the CAVLC total_zeros decoder.
// ----------------------------------------------------------------------------
package tzvd_pkg;

	localparam int unsigned TzRows    = 15;
	localparam int unsigned TzEntries = 16;
	localparam logic [3:0]  TzWinBits = 4'd9;

	typedef struct packed {
		logic [4:0] total_coeff;
		logic [8:0] bit_window;
	} tzvd_in_t;

	typedef struct packed {
		logic [3:0] total_zeros;
		logic [3:0] code_length;
		logic       code_error;
	} tzvd_out_t;

	// Codeword length per [total_coeff-1][total_zeros]; zero marks an unused entry.
	localparam logic [3:0] TZ_LEN [TzRows][TzEntries] = '{
		'{4'd1,4'd3,4'd3,4'd4,4'd4,4'd5,4'd5,4'd6,4'd6,4'd7,4'd7,4'd8,4'd8,4'd9,4'd9,4'd9},
		'{4'd3,4'd3,4'd3,4'd3,4'd3,4'd4,4'd4,4'd4,4'd4,4'd5,4'd5,4'd6,4'd6,4'd6,4'd6,4'd0},
		'{4'd4,4'd3,4'd3,4'd3,4'd4,4'd4,4'd3,4'd3,4'd4,4'd5,4'd5,4'd6,4'd5,4'd6,4'd0,4'd0},
		'{4'd5,4'd3,4'd4,4'd4,4'd3,4'd3,4'd3,4'd4,4'd3,4'd4,4'd5,4'd5,4'd5,4'd0,4'd0,4'd0},
		'{4'd4,4'd4,4'd4,4'd3,4'd3,4'd3,4'd3,4'd3,4'd4,4'd5,4'd4,4'd5,4'd0,4'd0,4'd0,4'd0},
		'{4'd6,4'd5,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd4,4'd3,4'd6,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd6,4'd5,4'd3,4'd3,4'd3,4'd2,4'd3,4'd4,4'd3,4'd6,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd6,4'd4,4'd5,4'd3,4'd2,4'd2,4'd3,4'd3,4'd6,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd6,4'd6,4'd4,4'd2,4'd2,4'd3,4'd2,4'd5,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd5,4'd5,4'd3,4'd2,4'd2,4'd2,4'd4,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd4,4'd4,4'd3,4'd3,4'd1,4'd3,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd4,4'd4,4'd2,4'd1,4'd3,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd3,4'd3,4'd1,4'd2,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd2,4'd2,4'd1,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0},
		'{4'd1,4'd1,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0}
	};

	// Right-aligned codeword value per [total_coeff-1][total_zeros].
	localparam logic [2:0] TZ_CODE [TzRows][TzEntries] = '{
		'{3'd1,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd1},
		'{3'd7,3'd6,3'd5,3'd4,3'd3,3'd5,3'd4,3'd3,3'd2,3'd3,3'd2,3'd3,3'd2,3'd1,3'd0,3'd0},
		'{3'd5,3'd7,3'd6,3'd5,3'd4,3'd3,3'd4,3'd3,3'd2,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0},
		'{3'd3,3'd7,3'd5,3'd4,3'd6,3'd5,3'd4,3'd3,3'd3,3'd2,3'd2,3'd1,3'd0,3'd0,3'd0,3'd0},
		'{3'd5,3'd4,3'd3,3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd1,3'd1,3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd1,3'd1,3'd5,3'd4,3'd3,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd1,3'd1,3'd1,3'd3,3'd3,3'd2,3'd2,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd1,3'd0,3'd1,3'd3,3'd2,3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd1,3'd0,3'd1,3'd3,3'd2,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd1,3'd2,3'd1,3'd3,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0},
		'{3'd0,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0}
	};

endpackage

/* sv/tzvd_decode.sv */
// ----------------------------------------------------------------------------
// tzvd_decode
// Table match of the peek window against the code table picked by the count.
// ----------------------------------------------------------------------------
module tzvd_decode (
	input  tzvd_pkg::tzvd_in_t  item,
	output tzvd_pkg::tzvd_out_t result
);
	import tzvd_pkg::*;

	logic                 in_range;
	logic [3:0]           row;
	logic [TzEntries-1:0] hit;
	logic [8:0]           prefix [TzEntries];
	logic [3:0]           len_row [TzEntries];
	logic [2:0]           code_row [TzEntries];

	assign in_range = (item.total_coeff[4] == 1'b0) && (item.total_coeff[3:0] != 4'd0);
	assign row      = in_range ? (item.total_coeff[3:0] - 4'd1) : 4'd0;

	// Every entry of the selected row is compared in parallel.
	always_comb begin
		for (int z = 0; z < TzEntries; z++) begin
			len_row[z]  = TZ_LEN[row][z];
			code_row[z] = TZ_CODE[row][z];
			prefix[z]   = item.bit_window >> (TzWinBits - len_row[z]);
			hit[z]      = (len_row[z] != 4'd0) && (prefix[z] == {6'd0, code_row[z]});
		end
	end

	// The lowest matching total_zeros wins.
	always_comb begin
		result.total_zeros = 4'd0;
		result.code_length = 4'd0;
		result.code_error  = 1'b1;
		for (int z = TzEntries - 1; z >= 0; z--) begin
			if (in_range && hit[z]) begin
				result.total_zeros = 4'(z);
				result.code_length = len_row[z];
				result.code_error  = 1'b0;
			end
		end
	end

endmodule

/* sv/total_zeros_vlc_decode.sv */
// ----------------------------------------------------------------------------
// total_zeros_vlc_decode
// CAVLC total_zeros decoder for 4x4 blocks: input register, table match,
// result register.
// ----------------------------------------------------------------------------
// An accepted input is captured in the input register; its decoded result
// is offered once it has been loaded into the result register.
// Throughput: one item per cycle while result_ready holds; the table match
// fits between the two registers, and an empty stage 1 loads in a stall.
// Reset (arst_n low) clears both stage valid flags; payload registers are
// not reset and no other state exists.
module total_zeros_vlc_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tzvd_pkg::tzvd_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output tzvd_pkg::tzvd_out_t result
);
	import tzvd_pkg::*;

	// Stage 1 holds the captured input item, stage 2 the decoded result.
	logic      valid_s1;
	tzvd_in_t  item_s1;
	logic      valid_s2;
	tzvd_out_t result_s2;
	tzvd_out_t decoded;
	logic      adv_s1;
	logic      adv_s2;

	// Stage 2 may load whenever it is empty or its result is being taken
	// this cycle; stage 1 may load whenever it is empty or moves on. This lets
	// a new transfer come in every cycle while the output is drained.
	assign adv_s2     = !valid_s2 || result_ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			item_s1 <= item;
		end
	end

	// The whole table match is combinational on the stage 1 register.
	tzvd_decode u_decode (
		.item   (item_s1),
		.result (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// An error result always reports zero consumed bits and a zero count.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.code_error) |->
		(result.code_length == 4'd0) && (result.total_zeros == 4'd0))
		else $error("error result carries nonzero fields");

	// A good result always has a codeword length of one to nine bits.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.code_error) |->
		(result.code_length != 4'd0) && (result.code_length <= TzWinBits))
		else $error("good result with bad code length");

	// An accepted input transfer lands in stage 1.
	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> valid_s1)
		else $error("accepted item lost before stage 1");

	// An out-of-range count moving to stage 2 becomes an error result.
	a_range_err: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && (item_s1.total_coeff[4] || (item_s1.total_coeff == 5'd0)))
		|=> (valid_s2 && result_s2.code_error))
		else $error("out-of-range count not flagged");

endmodule
